// File: hdl/kfci_pkg.sv
// Shared types, constants and helpers for the keyframe curve interpolator.
// No dependencies; used by the key cell, the divider and the top level.
package kfci_pkg;

   localparam int TIME_W    = 17;
   localparam int VALUE_W   = 32;
   localparam int INDEX_W   = 3;
   localparam int COUNT_W   = 4;
   localparam int DIFF_W    = VALUE_W + 1;
   localparam int PROD_W    = VALUE_W + TIME_W;
   localparam int QUO_W     = 32;
   localparam int DIV_CNT_W = 4;

   localparam logic [TIME_W-1:0] TIME_ONE = 17'h10000;

   localparam logic ACT_WRITE = 1'b0;
   localparam logic ACT_EVAL  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_PREP,
      ST_ABS,
      ST_MUL,
      ST_DSTART,
      ST_DIV,
      ST_DONE
   } state_type;

   // Search token that walks down the row of key cells.
   typedef struct packed {
      logic                valid;
      logic [TIME_W-1:0]   qtime;
      logic                done;
      logic                found;
      logic [VALUE_W-1:0]  res_value;
      logic [TIME_W-1:0]   lo_time;
      logic [VALUE_W-1:0]  lo_value;
      logic [TIME_W-1:0]   up_time;
      logic [VALUE_W-1:0]  up_value;
   } key_tok_type;

   function automatic logic [TIME_W-1:0] clamp_time(input logic [TIME_W-1:0] t);
      return (t > TIME_ONE) ? TIME_ONE : t;
   endfunction

endpackage

// File: hdl/kfci_cell.sv
// One key cell: stores one (time, value) key and advances the search token by one step.
// Depends on kfci_pkg.
module kfci_cell import kfci_pkg::*; #(
   parameter int IDX   = 0,
   parameter int CNT_W = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                wr_en,
   input  logic [INDEX_W-1:0]  wr_index,
   input  logic [TIME_W-1:0]   wr_time,
   input  logic [VALUE_W-1:0]  wr_value,
   input  logic [CNT_W-1:0]    n_keys,
   input  logic [TIME_W-1:0]   prev_time,
   input  logic [VALUE_W-1:0]  prev_value,
   output logic [TIME_W-1:0]   own_time,
   output logic [VALUE_W-1:0]  own_value,
   input  key_tok_type         tok_in,
   output key_tok_type         tok_out
);

   logic [TIME_W-1:0]  time_ff;
   logic [VALUE_W-1:0] value_ff;
   key_tok_type        tok_ff;
   key_tok_type        tok_in_next;
   logic               wr_hit;
   logic               in_use;
   logic               is_last;

   assign wr_hit  = wr_en && (int'(wr_index) == IDX);
   assign in_use  = CNT_W'(IDX) < n_keys;
   assign is_last = n_keys == CNT_W'(IDX + 1);

   always_ff @(posedge clock) begin
      if (wr_hit) begin
         time_ff  <= wr_time;
         value_ff <= wr_value;
      end
   end

   always_comb begin
      tok_in_next = tok_in;
      if (tok_in.valid && !tok_in.done) begin
         if (IDX == 0) begin
            // Key 0 settles an empty or one-key curve and every time at or before it.
            if (n_keys == '0) begin
               tok_in_next.done      = 1'b1;
               tok_in_next.res_value = '0;
            end else if (tok_in.qtime <= time_ff || is_last) begin
               tok_in_next.done      = 1'b1;
               tok_in_next.res_value = value_ff;
            end
         end else if (in_use) begin
            if (!tok_in.found && tok_in.qtime < time_ff) begin
               tok_in_next.found    = 1'b1;
               tok_in_next.lo_time  = prev_time;
               tok_in_next.lo_value = prev_value;
               tok_in_next.up_time  = time_ff;
               tok_in_next.up_value = value_ff;
            end
            // At or past the last key the last value wins over any segment found earlier.
            if (is_last && tok_in.qtime >= time_ff) begin
               tok_in_next.done      = 1'b1;
               tok_in_next.res_value = value_ff;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff <= tok_in_next;
      end
   end

   assign tok_out   = tok_ff;
   assign own_time  = time_ff;
   assign own_value = value_ff;

endmodule

// File: hdl/kfci_div.sv
// Iterative restoring divider, two quotient bits per cycle, for the segment fraction.
// Depends on kfci_pkg.
module kfci_div import kfci_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  logic [PROD_W-1:0]  dividend,
   input  logic [TIME_W-1:0]  divisor,
   output logic               done,
   output logic [QUO_W-1:0]   quotient
);

   logic                 busy_ff;
   logic                 done_ff;
   logic [DIV_CNT_W-1:0] cnt_ff;
   logic [TIME_W-1:0]    rem_ff;
   logic [QUO_W-1:0]     low_ff;
   logic [QUO_W-1:0]     quo_ff;

   logic [TIME_W:0]      r1;
   logic [TIME_W:0]      r2;
   logic [TIME_W:0]      s1;
   logic [TIME_W:0]      s2;
   logic                 q1;
   logic                 q2;

   always_comb begin
      r1 = {rem_ff, low_ff[QUO_W-1]};
      q1 = r1 >= {1'b0, divisor};
      s1 = q1 ? r1 - {1'b0, divisor} : r1;
      r2 = {s1[TIME_W-1:0], low_ff[QUO_W-2]};
      q2 = r2 >= {1'b0, divisor};
      s2 = q2 ? r2 - {1'b0, divisor} : r2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= busy_ff && (cnt_ff == '0);
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '1;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   // The upper dividend bits are always below the divisor, so they seed the remainder.
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff <= dividend[PROD_W-1:QUO_W];
         low_ff <= dividend[QUO_W-1:0];
         quo_ff <= '0;
      end else if (busy_ff) begin
         rem_ff <= s2[TIME_W-1:0];
         low_ff <= {low_ff[QUO_W-3:0], 2'b00};
         quo_ff <= {quo_ff[QUO_W-3:0], q1, q2};
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// File: hdl/keyframe_curve_interpolator_top.sv
// Top level of the keyframe curve interpolator: row of key cells, control and arithmetic.
// Depends on kfci_pkg, kfci_cell and kfci_div.
//
//   port group   direction  handshake            payload
//   req_*        in         req_valid/req_stall  action, key_index, key_time, key_value,
//                                                query_time
//   rsp_*        out        rsp_valid/rsp_stall  curve_value
//   csr_*        in         csr_wr_en            csr_wr_data (key_count)
//
// A write item is taken in the idle state. An evaluate item walks the key row, then passes
// through setup, absolute value and multiply; a curve end, an empty curve or a segment
// without positive span is then finished, and an interior time also runs the divider
// (two quotient bits per cycle). One item is in work at a time.
// Reset is synchronous; key storage has no reset and key_count clears to zero.
// A finished result waits in the output register while a new item is taken.
module keyframe_curve_interpolator_top import kfci_pkg::*; #(
   parameter int MAX_KEYS = 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_action,
   input  logic [INDEX_W-1:0]        req_key_index,
   input  logic [TIME_W-1:0]         req_key_time,
   input  logic signed [VALUE_W-1:0] req_key_value,
   input  logic [TIME_W-1:0]         req_query_time,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [VALUE_W-1:0] rsp_curve_value,
   input  logic                      csr_wr_en,
   input  logic [COUNT_W-1:0]        csr_wr_data
);

   localparam int CNT_W = $clog2(MAX_KEYS + 1);
   localparam int CMP_W = (CNT_W > COUNT_W) ? CNT_W : COUNT_W;

   state_type state_ff;
   state_type state_in;

   logic [COUNT_W-1:0] key_count_ff;
   logic [CNT_W-1:0]   n_keys;

   key_tok_type        head_tok;
   key_tok_type        tok_w [MAX_KEYS+1];
   logic [TIME_W-1:0]  key_time_w  [MAX_KEYS];
   logic [VALUE_W-1:0] key_value_w [MAX_KEYS];
   logic [MAX_KEYS-1:0] tok_valid;
   key_tok_type        tail_tok;

   logic req_acc;
   logic wr_acc;
   logic inject;
   logic cap_tail;
   logic div_start;
   logic load_rsp;
   logic rsp_free;

   key_tok_type        sel_ff;
   logic [DIFF_W-1:0]  d_ff;
   logic [DIFF_W-1:0]  d_in;
   logic [DIFF_W-1:0]  neg_d;
   logic [TIME_W-1:0]  num_ff;
   logic [TIME_W-1:0]  num_in;
   logic [TIME_W-1:0]  span_ff;
   logic [TIME_W-1:0]  span_in;
   logic               direct_ff;
   logic               neg_ff;
   logic [VALUE_W-1:0] mag_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [PROD_W-1:0]  prod_in;
   logic [PROD_W-1:0]  dividend;
   logic [VALUE_W-1:0] res_ff;
   logic               rsp_valid_ff;
   logic [VALUE_W-1:0] rsp_curve_value_ff;

   logic               div_done;
   logic [QUO_W-1:0]   div_quo;

   // ---------------------------------------------------------------- control register
   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= '0;
      end else if (csr_wr_en) begin
         key_count_ff <= csr_wr_data;
      end
   end

   assign n_keys = (CMP_W'(key_count_ff) > CMP_W'(MAX_KEYS)) ? CNT_W'(MAX_KEYS)
                                                             : CNT_W'(key_count_ff);

   // ---------------------------------------------------------------- key row
   assign req_acc = req_valid && !req_stall;
   assign wr_acc  = req_acc && (req_action == ACT_WRITE);

   always_comb begin
      head_tok       = '0;
      head_tok.valid = inject;
      head_tok.qtime = clamp_time(req_query_time);
   end

   assign tok_w[0] = head_tok;

   for (genvar i = 0; i < MAX_KEYS; i++) begin : g_cell
      logic [TIME_W-1:0]  prev_time;
      logic [VALUE_W-1:0] prev_value;

      if (i == 0) begin : g_first
         assign prev_time  = '0;
         assign prev_value = '0;
      end else begin : g_next
         assign prev_time  = key_time_w[i-1];
         assign prev_value = key_value_w[i-1];
      end

      kfci_cell #(
         .IDX   (i),
         .CNT_W (CNT_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .wr_en      (wr_acc),
         .wr_index   (req_key_index),
         .wr_time    (clamp_time(req_key_time)),
         .wr_value   (req_key_value),
         .n_keys     (n_keys),
         .prev_time  (prev_time),
         .prev_value (prev_value),
         .own_time   (key_time_w[i]),
         .own_value  (key_value_w[i]),
         .tok_in     (tok_w[i]),
         .tok_out    (tok_w[i+1])
      );

      assign tok_valid[i] = tok_w[i+1].valid;
   end

   assign tail_tok = tok_w[MAX_KEYS];

   // ---------------------------------------------------------------- state machine
   assign rsp_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_action == ACT_EVAL) begin
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (tail_tok.valid) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP:   state_in = ST_ABS;
         ST_ABS:    state_in = ST_MUL;
         ST_MUL:    state_in = direct_ff ? ST_DONE : ST_DSTART;
         ST_DSTART: state_in = ST_DIV;
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall = 1'b1;
      inject    = 1'b0;
      cap_tail  = 1'b0;
      div_start = 1'b0;
      load_rsp  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            inject    = req_valid && req_action == ACT_EVAL;
         end
         ST_SEARCH: cap_tail  = tail_tok.valid;
         ST_DSTART: div_start = 1'b1;
         ST_DONE:   load_rsp  = rsp_free;
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // ---------------------------------------------------------------- segment arithmetic
   always_comb begin
      d_in    = {sel_ff.up_value[VALUE_W-1], sel_ff.up_value}
              - {sel_ff.lo_value[VALUE_W-1], sel_ff.lo_value};
      num_in  = (sel_ff.qtime >= sel_ff.lo_time) ? sel_ff.qtime - sel_ff.lo_time : '0;
      span_in = sel_ff.up_time - sel_ff.lo_time;
      neg_d   = '0 - d_ff;
      prod_in = mag_ff * num_ff;
      dividend = prod_ff + PROD_W'(span_ff >> 1);
   end

   always_ff @(posedge clock) begin
      if (cap_tail) begin
         sel_ff <= tail_tok;
      end
      case (state_ff)
         ST_PREP: begin
            d_ff      <= d_in;
            num_ff    <= num_in;
            span_ff   <= span_in;
            // A resolved end, a search without a segment, or a segment without positive span, takes no division.
            direct_ff <= sel_ff.done || !sel_ff.found || (sel_ff.up_time <= sel_ff.lo_time);
         end
         ST_ABS: begin
            neg_ff    <= d_ff[DIFF_W-1];
            mag_ff    <= d_ff[DIFF_W-1] ? neg_d[VALUE_W-1:0] : d_ff[VALUE_W-1:0];
            direct_ff <= direct_ff || (num_ff >= span_ff);
         end
         ST_MUL: begin
            prod_ff <= prod_in;
            if (direct_ff) begin
               res_ff <= sel_ff.done ? sel_ff.res_value : sel_ff.up_value;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               res_ff <= neg_ff ? sel_ff.lo_value - div_quo : sel_ff.lo_value + div_quo;
            end
         end
         default: begin
            res_ff <= res_ff;
         end
      endcase
   end

   kfci_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (dividend),
      .divisor  (span_ff),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ---------------------------------------------------------------- output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load_rsp) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_curve_value_ff <= res_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_curve_value = rsp_curve_value_ff;

   // ---------------------------------------------------------------- assertions
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(tok_valid))
      else $error("more than one search token in the key row");

   a_tail_in_search: assert property (@(posedge clock) disable iff (reset)
      tail_tok.valid |-> state_ff == ST_SEARCH)
      else $error("search token left the key row outside the search state");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide state");

   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DONE && rsp_free) |=> (rsp_valid_ff && state_ff == ST_IDLE))
      else $error("finished item was not moved to the output register");

endmodule

// File: verif/testbench.sv
// Self-checking testbench for keyframe_curve_interpolator_top: key loads, curve evaluation
// and key_count settings, checked against an in-line curve predictor.
// Depends on kfci_pkg and the RTL under hdl/.
module testbench import kfci_pkg::*; ();

   localparam int KEY_SLOTS    = 8;
   localparam int DRAIN_CYCLES = KEY_SLOTS + 32;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int ITEM_TARGET  = 1750;

   class curve_scoreboard;
      logic [TIME_W-1:0]  key_time_tab [KEY_SLOTS];
      logic [VALUE_W-1:0] key_value_tab [KEY_SLOTS];
      logic [COUNT_W-1:0] key_count;
      logic [VALUE_W-1:0] pending_curve_values [$];
      int                 n_items;
      int                 n_results;
      int                 n_errors;

      function new();
         foreach (key_time_tab[i]) begin
            key_time_tab[i]  = '0;
            key_value_tab[i] = '0;
         end
         key_count = '0;
         n_items   = 0;
         n_results = 0;
         n_errors  = 0;
      endfunction

      function int pending();
         return pending_curve_values.size();
      endfunction

      function void set_count(logic [COUNT_W-1:0] c);
         key_count = c;
      endfunction

      function logic [VALUE_W-1:0] curve_at(logic [TIME_W-1:0] qt);
         int unsigned       n;
         int unsigned       up;
         int unsigned       lo;
         int unsigned       j;
         bit                found;
         logic [TIME_W-1:0] t;
         longint            d;
         longint            r;
         longint unsigned   mag;
         longint unsigned   num;
         longint unsigned   span;
         longint unsigned   q;
         t = (qt > TIME_ONE) ? TIME_ONE : qt;
         n = (key_count > KEY_SLOTS) ? KEY_SLOTS : key_count;
         if (n == 0)
            return '0;
         if (t <= key_time_tab[0])
            return key_value_tab[0];
         if (t >= key_time_tab[n-1])
            return key_value_tab[n-1];
         // The upper key is the first one past the query time, whatever the key order.
         up = n - 1;
         found = 1'b0;
         for (j = 1; j < n; j++) begin
            if (!found && t < key_time_tab[j]) begin
               up = j;
               found = 1'b1;
            end
         end
         lo = up - 1;
         if (key_time_tab[up] <= key_time_tab[lo])
            return key_value_tab[up];
         span = key_time_tab[up] - key_time_tab[lo];
         num = (t >= key_time_tab[lo]) ? t - key_time_tab[lo] : 0;
         if (num >= span)
            return key_value_tab[up];
         d = longint'($signed(key_value_tab[up])) - longint'($signed(key_value_tab[lo]));
         mag = (d < 0) ? -d : d;
         // Halves round away from zero because the magnitude is rounded before the sign.
         q = (mag * num + span / 2) / span;
         r = longint'($signed(key_value_tab[lo])) + ((d < 0) ? -longint'(q) : longint'(q));
         return r[VALUE_W-1:0];
      endfunction

      function void note_item(logic act, logic [INDEX_W-1:0] idx, logic [TIME_W-1:0] kt,
                              logic [VALUE_W-1:0] kv, logic [TIME_W-1:0] qt);
         n_items++;
         if (act == ACT_WRITE) begin
            key_time_tab[idx]  = (kt > TIME_ONE) ? TIME_ONE : kt;
            key_value_tab[idx] = kv;
         end else begin
            pending_curve_values.insert(pending_curve_values.size(), curve_at(qt));
         end
      endfunction

      task report_mismatch(string what);
         n_errors++;
         $display("ERROR at %0t: %s", $realtime, what);
      endtask

      task check_result(logic [VALUE_W-1:0] got);
         logic [VALUE_W-1:0] want;
         n_results++;
         if (pending_curve_values.size() == 0) begin
            report_mismatch($sformatf("curve_value %0d arrived with nothing pending",
                                      $signed(got)));
         end else begin
            want = pending_curve_values.pop_front();
            if (got !== want)
               report_mismatch($sformatf("curve_value %0d, predicted %0d",
                                         $signed(got), $signed(want)));
         end
      endtask
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic                req_action = ACT_EVAL;
   logic [INDEX_W-1:0]  req_key_index = '0;
   logic [TIME_W-1:0]   req_key_time = '0;
   logic [VALUE_W-1:0]  req_key_value = '0;
   logic [TIME_W-1:0]   req_query_time = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [VALUE_W-1:0]  rsp_curve_value;
   logic                csr_wr_en = 1'b0;
   logic [COUNT_W-1:0]  csr_wr_data = '0;

   curve_scoreboard sb;
   bit              req_quiet = 1'b0;
   bit              rsp_quiet = 1'b0;
   int              stall_left = 0;
   int              cycle_count = 0;
   int              n_settings = 0;

   keyframe_curve_interpolator_top #(
      .MAX_KEYS(KEY_SLOTS)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_key_index  (req_key_index),
      .req_key_time   (req_key_time),
      .req_key_value  (req_key_value),
      .req_query_time (req_query_time),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_curve_value(rsp_curve_value),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("keyframe_curve_interpolator_top: mismatch");
         $finish;
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int idle_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 45)
         return 0;
      else if (r < 85)
         return $urandom_range(1, 3);
      else if (r < 97)
         return $urandom_range(4, 15);
      return $urandom_range(20, 60);
   endfunction

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall == 1'b0)
         sb.check_result(rsp_curve_value);
      if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
         if (!rsp_quiet && $urandom_range(0, 2) == 0)
            stall_left = idle_len();
      end
   end

   function automatic logic [VALUE_W-1:0] rand_value();
      case ($urandom_range(0, 7))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2, 3: return VALUE_W'($urandom_range(0, 2000)) - VALUE_W'(1000);
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [TIME_W-1:0] next_query();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return TIME_ONE;
         2: return TIME_W'($urandom_range(65537, 131071));
         3, 4, 5: return sb.key_time_tab[$urandom_range(0, KEY_SLOTS-1)]
                         + TIME_W'($urandom_range(0, 4)) - TIME_W'(2);
         default: return TIME_W'($urandom_range(0, 65536));
      endcase
   endfunction

   // Called right after a rising edge; returns once the item is taken, after an optional idle gap.
   task automatic send_item(logic act, logic [INDEX_W-1:0] idx, logic [TIME_W-1:0] kt,
                            logic [VALUE_W-1:0] kv, logic [TIME_W-1:0] qt);
      int gap;
      req_valid      <= 1'b1;
      req_action     <= act;
      req_key_index  <= idx;
      req_key_time   <= kt;
      req_key_value  <= kv;
      req_query_time <= qt;
      @(posedge clock);
      while (req_stall !== 1'b0)
         @(posedge clock);
      sb.note_item(act, idx, kt, kv, qt);
      gap = req_quiet ? 0 : idle_len();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_eval(logic [TIME_W-1:0] qt);
      send_item(ACT_EVAL, INDEX_W'($urandom_range(0, KEY_SLOTS-1)),
                TIME_W'($urandom_range(0, 131071)), $urandom, qt);
   endtask

   task automatic send_key(logic [INDEX_W-1:0] idx, logic [TIME_W-1:0] kt,
                           logic [VALUE_W-1:0] kv);
      send_item(ACT_WRITE, idx, kt, kv, TIME_W'($urandom_range(0, 131071)));
   endtask

   // key_count only changes with the block idle; a trailing key write gives no result,
   // so wait out a full evaluate latency after the last result as well.
   task automatic write_count(logic [COUNT_W-1:0] c);
      req_valid <= 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= c;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      sb.set_count(c);
      n_settings++;
   endtask

   task automatic load_keys(bit ordered, bit reverse);
      logic [TIME_W-1:0]  tt [KEY_SLOTS];
      logic [VALUE_W-1:0] vv [KEY_SLOTS];
      int unsigned        t;
      int unsigned        spread;
      int                 k;
      int                 slot;
      case ($urandom_range(0, 2))
         0: spread = 3;
         1: spread = 300;
         default: spread = 7000;
      endcase
      t = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 2000);
      for (k = 0; k < KEY_SLOTS; k++) begin
         if (ordered) begin
            tt[k] = TIME_W'(t);
            t = t + 1 + $urandom_range(0, spread);
         end else begin
            case ($urandom_range(0, 2))
               0: tt[k] = TIME_W'($urandom_range(0, 131071));
               1: tt[k] = (k > 0) ? tt[k-1] : '0;
               default: tt[k] = TIME_W'($urandom_range(0, 65536));
            endcase
         end
         vv[k] = rand_value();
      end
      if (ordered && $urandom_range(0, 7) == 0)
         tt[KEY_SLOTS-1] = TIME_W'($urandom_range(65536, 131071));
      for (k = 0; k < KEY_SLOTS; k++) begin
         slot = reverse ? KEY_SLOTS - 1 - k : k;
         send_key(INDEX_W'(slot), tt[slot], vv[slot]);
      end
   endtask

   initial begin
      int n_eval;
      int style;
      int e;
      logic [COUNT_W-1:0] c;
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Empty curve straight out of reset, including a time above one.
      send_eval('0);
      send_eval(TIME_ONE);
      send_eval(17'h1FFFF);

      // Full-scale swings, a rounding half between slots 4 and 5, last key time clamped.
      send_key(3'd0, 17'd0,     32'h8000_0000);
      send_key(3'd1, 17'd1000,  32'h7FFF_FFFF);
      send_key(3'd2, 17'd1001,  32'h8000_0000);
      send_key(3'd3, 17'd20000, 32'h0000_0000);
      send_key(3'd4, 17'd20000, 32'd12346);
      send_key(3'd5, 17'd20002, 32'd1);
      send_key(3'd6, 17'd65535, 32'hFFFF_FFF9);
      send_key(3'd7, 17'h1FFFF, 32'h7FFF_FFFF);

      write_count(4'd8);
      send_eval(17'd0);
      send_eval(17'd500);
      send_eval(17'd1000);
      send_eval(17'd1001);
      send_eval(17'd1500);
      send_eval(17'd20001);
      send_eval(17'd40000);
      send_eval(17'd65535);
      send_eval(TIME_ONE);
      send_eval(17'h1FFFF);
      write_count(4'd15);
      send_eval(17'd30000);
      write_count(4'd1);
      send_eval(17'd100);
      write_count(4'd2);
      send_eval(17'd500);

      while (sb.n_items < ITEM_TARGET) begin
         case ($urandom_range(0, 9))
            0: c = 4'd0;
            1: c = 4'd1;
            2: c = 4'd2;
            3, 4: c = 4'd8;
            5: c = COUNT_W'($urandom_range(9, 15));
            default: c = COUNT_W'($urandom_range(0, 15));
         endcase
         write_count(c);
         req_quiet = ($urandom_range(0, 4) == 0);
         rsp_quiet = ($urandom_range(0, 4) == 0);
         style = $urandom_range(0, 9);
         if (style < 7)
            load_keys(1'b1, 1'($urandom_range(0, 1)));
         else if (style < 9)
            load_keys(1'b0, 1'($urandom_range(0, 1)));
         n_eval = $urandom_range(15, 50);
         for (e = 0; e < n_eval; e++) begin
            if ($urandom_range(0, 9) == 0)
               send_key(INDEX_W'($urandom_range(0, KEY_SLOTS-1)),
                        TIME_W'($urandom_range(0, 131071)), rand_value());
            else
               send_eval(next_query());
         end
      end

      req_valid <= 1'b0;
      rsp_quiet = 1'b0;
      while (sb.pending() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d items, checked %0d curve values over %0d key_count settings.",
               sb.n_items, sb.n_results, n_settings);
      $display("Errors found: %0d", sb.n_errors);
      if (sb.n_errors == 0)
         $display("keyframe_curve_interpolator_top: match");
      else
         $display("keyframe_curve_interpolator_top: mismatch");
      $finish;
   end

endmodule

// File: files.f
hdl/kfci_pkg.sv
hdl/kfci_cell.sv
hdl/kfci_div.sv
hdl/keyframe_curve_interpolator_top.sv
verif/testbench.sv
